// ----- src/kcl_pkg.sv -----
// Shared types, constants and helpers for the keypad code lock.
// Used by the front classifier, the item queue, the back sequencer and the top level.
package kcl_pkg;

  localparam int KEY_COUNT        = 10;
  localparam int KEY_IDX_W        = 4;
  localparam int DIGIT_W          = 4;
  localparam int TICK_W           = 16;
  localparam int CODE_REG_W       = 16;
  localparam int DIGITS_OUT_W     = 3;
  localparam int CODE_LENGTH_DEF  = 4;
  localparam int S_TDATA_W        = 16;
  localparam int M_TDATA_W        = 16;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;

  localparam logic [CODE_REG_W-1:0] SECRET_CODE_RST    = 16'h1234;
  localparam logic [TICK_W-1:0]     DEBOUNCE_TICKS_RST = 16'd10000;

  // Register indexes on the configuration port
  localparam logic REG_SECRET_CODE    = 1'b0;
  localparam logic REG_DEBOUNCE_TICKS = 1'b1;

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_GRANTED = 2'd1;
  localparam logic [1:0] VERDICT_DENIED  = 2'd2;

  // Motor bridge settings, bit 0 = in1, bit 1 = in2
  localparam logic [1:0] BRIDGE_OFF     = 2'b00;
  localparam logic [1:0] BRIDGE_REVERSE = 2'b10;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COLLECT  = 3'd1,
    PH_DEBOUNCE = 3'd2,
    PH_RELEASE  = 3'd3,
    PH_HOLDOFF  = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  // One classified item on its way from front to back
  typedef struct packed {
    logic [KEY_COUNT-1:0] key_map;
    logic [KEY_IDX_W-1:0] first_key;
    logic                 key_any;
    logic                 start_button;
    logic                 motor_button;
  } key_item_t;

  // Digit printed on each key of the matrix, in scan order
  function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_IDX_W-1:0] idx);
    logic [DIGIT_W-1:0] d;
    case (idx)
      4'd0:    d = 4'd7;
      4'd1:    d = 4'd8;
      4'd2:    d = 4'd9;
      4'd3:    d = 4'd4;
      4'd4:    d = 4'd5;
      4'd5:    d = 4'd6;
      4'd6:    d = 4'd1;
      4'd7:    d = 4'd2;
      4'd8:    d = 4'd3;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- src/kcl_front.sv -----
// Front end of the keypad code lock: unpacks an input item and finds the first pressed key.
// Depends on kcl_pkg for the item struct.
module kcl_front import kcl_pkg::*; (
  input  logic [S_TDATA_W-1:0] s_tdata,  // key_map[9:0], start_button[10], motor_button[11]
  output key_item_t            item
);

  logic [KEY_IDX_W-1:0] first_key;
  logic                 key_any;

  // Pick the lowest set bit of the key matrix
  always_comb begin
    first_key = '0;
    key_any   = 1'b0;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (s_tdata[k]) begin
        first_key = KEY_IDX_W'(k);
        key_any   = 1'b1;
      end
    end
  end

  // Build the classified item
  always_comb begin
    item.key_map      = s_tdata[KEY_COUNT-1:0];
    item.first_key    = first_key;
    item.key_any      = key_any;
    item.start_button = s_tdata[KEY_COUNT];
    item.motor_button = s_tdata[KEY_COUNT+1];
  end

endmodule

// ----- src/kcl_queue.sv -----
// Two-entry item queue between the front and the back of the keypad code lock.
// Depends on kcl_pkg for the item struct.
module kcl_queue import kcl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  key_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output key_item_t head
);

  key_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ----- src/kcl_back.sv -----
// Back end of the keypad code lock: session sequencer, digit store, code check, output register.
// Depends on kcl_pkg for the phase type, item struct, codes and key digit table.
module kcl_back import kcl_pkg::*; #(
  parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  key_item_t             item,
  output logic                  item_pop,
  input  logic [CODE_REG_W-1:0] secret_code,
  input  logic [TICK_W-1:0]     debounce_ticks,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int EXT_W = DIGIT_W * CODE_LENGTH;

  phase_t             phase, phase_next;
  logic [TICK_W-1:0]  wait_counter, wait_counter_next;
  logic [KEY_IDX_W-1:0] held_key, held_key_next;
  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [1:0]         verdict_reg, verdict_next;
  logic [1:0]         motor_reg, motor_next;
  logic [DIGIT_W-1:0] digit_store [CODE_LENGTH];
  logic               store_we;
  logic               echo;
  logic               count_done;
  logic               held_down;
  logic               store_full;
  logic               code_ok;
  logic [EXT_W+CODE_REG_W-1:0] code_ext;
  logic [M_TDATA_W-1:0] out_data;

  assign item_pop   = item_valid && (!m_tvalid || m_tready);
  assign count_done = (wait_counter <= TICK_W'(1));
  assign held_down  = item.key_map[held_key];
  assign store_full = (digit_count >= CNT_W'(CODE_LENGTH));
  assign code_ext   = (EXT_W + CODE_REG_W)'(secret_code);

  // Compare stored digits with the code, first digit in the top nibble
  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digit_store[i] != code_ext[DIGIT_W*(CODE_LENGTH-1-i) +: DIGIT_W]) code_ok = 1'b0;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:     if (item.start_button) phase_next = PH_COLLECT;
      PH_COLLECT:  if (item.key_any) phase_next = PH_DEBOUNCE;
      PH_DEBOUNCE: if (count_done) phase_next = PH_RELEASE;
      PH_RELEASE:  if (!held_down) phase_next = PH_HOLDOFF;
      PH_HOLDOFF: begin
        if (count_done) phase_next = store_full ? PH_DONE : PH_COLLECT;
      end
      default:     phase_next = PH_DONE;
    endcase
  end

  // Datapath updates per phase
  always_comb begin
    wait_counter_next = wait_counter;
    held_key_next     = held_key;
    digit_count_next  = digit_count;
    verdict_next      = verdict_reg;
    motor_next        = motor_reg;
    store_we          = 1'b0;
    echo              = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.start_button) digit_count_next = '0;
      end
      PH_COLLECT: begin
        if (item.key_any) begin
          held_key_next     = item.first_key;
          wait_counter_next = debounce_ticks;
        end
      end
      PH_DEBOUNCE: begin
        wait_counter_next = count_done ? '0 : wait_counter - TICK_W'(1);
      end
      PH_RELEASE: begin
        if (!held_down) begin
          if (!store_full) begin
            store_we         = 1'b1;
            digit_count_next = digit_count + CNT_W'(1);
          end
          echo              = 1'b1;
          wait_counter_next = debounce_ticks;
        end
      end
      PH_HOLDOFF: begin
        wait_counter_next = count_done ? '0 : wait_counter - TICK_W'(1);
        if (count_done && store_full) begin
          if (code_ok) begin
            verdict_next = VERDICT_GRANTED;
            motor_next   = item.motor_button ? BRIDGE_OFF : BRIDGE_REVERSE;
          end else begin
            verdict_next = VERDICT_DENIED;
            motor_next   = BRIDGE_OFF;
          end
        end
      end
      default: ;
    endcase
  end

  // Result item from the updated state
  always_comb begin
    out_data    = '0;
    out_data[0] = (phase_next == PH_COLLECT) || (phase_next == PH_DEBOUNCE) ||
                  (phase_next == PH_RELEASE) || (phase_next == PH_HOLDOFF);
    out_data[3:1] = DIGITS_OUT_W'(digit_count_next);
    out_data[4]   = echo;
    out_data[6:5] = verdict_next;
    out_data[7]   = motor_next[0];
    out_data[8]   = motor_next[1];
  end

  // Hold control state, advance on each popped item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_counter <= '0;
      held_key     <= '0;
      digit_count  <= '0;
      verdict_reg  <= VERDICT_NONE;
      motor_reg    <= BRIDGE_OFF;
    end else if (item_pop) begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
      held_key     <= held_key_next;
      digit_count  <= digit_count_next;
      verdict_reg  <= verdict_next;
      motor_reg    <= motor_next;
    end
  end

  // Store the accepted digit
  always_ff @(posedge clk) begin
    if (item_pop && store_we) digit_store[digit_count[IDX_W-1:0]] <= key_digit(held_key);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) m_tdata <= out_data;
  end

  a_verdict_only_when_done: assert property (@(posedge clk) disable iff (rst)
    (verdict_reg != VERDICT_NONE) |-> (phase == PH_DONE))
    else $error("verdict set outside the done phase");

  a_done_is_final: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("left the done phase without reset");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(CODE_LENGTH))
    else $error("digit count beyond code length");

  a_collect_has_room: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLLECT) |-> !store_full)
    else $error("collecting with a full digit store");

  a_in1_low: assert property (@(posedge clk) disable iff (rst)
    !motor_reg[0])
    else $error("motor input one driven high");

endmodule

// ----- src/keypad_code_lock.sv -----
// Keypad code lock: one item per cycle while m_tready is high; each gives one result item.
// An accepted item is written to the queue and then popped into the output
// register, which raises m_tvalid to offer the result item.
// While a result waits on m_tready the queue holds up to two items; s_tready drops when full.
// Reset (rst, synchronous) empties the queue and output register and returns the
// sequencer to idle with the configuration registers at their defaults; no clearing pass.
module keypad_code_lock import kcl_pkg::*; #(
  parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,  // key_map[9:0], start_button[10], motor_button[11]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // session_active[0], digits_entered[3:1], echo_star[4], verdict[6:5],
  // bridge_a[7], bridge_b[8]
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CODE_REG_W-1:0] secret_code;
  logic [TICK_W-1:0]     debounce_ticks;
  logic                  cfg_write;
  key_item_t             front_item;
  key_item_t             head_item;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign s_tready  = !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      secret_code    <= SECRET_CODE_RST;
      debounce_ticks <= DEBOUNCE_TICKS_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SECRET_CODE:    secret_code    <= pwdata[CODE_REG_W-1:0];
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      REG_SECRET_CODE:    prdata = APB_DATA_W'(secret_code);
      REG_DEBOUNCE_TICKS: prdata = APB_DATA_W'(debounce_ticks);
      default:            prdata = '0;
    endcase
  end

  kcl_front u_front (
    .s_tdata (s_tdata),
    .item    (front_item)
  );

  kcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  kcl_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (q_not_empty),
    .item           (head_item),
    .item_pop       (q_pop),
    .secret_code    (secret_code),
    .debounce_ticks (debounce_ticks),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule

// ----- tb/sv/tb_keypad_code_lock.sv -----
`timescale 1ns / 1ps
// Testbench for keypad_code_lock: sends key matrix ticks on the stream port and
// checks every status item against a lock model kept here. Needs kcl_pkg.
module tb_keypad_code_lock;
  import kcl_pkg::*;

  // Status item as it sits on m_tdata, last field in the lowest bits
  typedef struct packed {
    logic [6:0]              pad;
    logic                    bridge_b;
    logic                    bridge_a;
    logic [1:0]              verdict;
    logic                    echo_star;
    logic [DIGITS_OUT_W-1:0] digits_entered;
    logic                    session_active;
  } lock_status_t;

  localparam logic [APB_ADDR_W-1:0] ADDR_CODE  = {REG_SECRET_CODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_TICKS = {REG_DEBOUNCE_TICKS, 2'b00};

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Lock model state and its copy of the registers
  phase_t               lk_phase;
  logic [TICK_W-1:0]    lk_wait;
  logic [KEY_IDX_W-1:0] lk_key;
  logic [DIGIT_W-1:0]   lk_digits [CODE_LENGTH_DEF];
  logic [2:0]           lk_count;
  logic [1:0]           lk_verdict;
  logic [1:0]           lk_motor;
  logic [15:0]          cfg_code;
  logic [15:0]          cfg_ticks;

  lock_status_t pending_status [$];
  int           err_count   = 0;
  int           tx_idle_pct = 6;
  int           rx_idle_pct = 87;

  keypad_code_lock i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
    err_count++;
  endtask

  // Printed digit of a key from its scan position: rows run 7-8-9, 4-5-6, 1-2-3, then 0
  function automatic logic [DIGIT_W-1:0] face_digit(logic [KEY_IDX_W-1:0] idx);
    int r;
    int c;
    r = idx / 3;
    c = idx % 3;
    if (idx == 4'd9) return 4'd0;
    return DIGIT_W'(3 * (2 - r) + c + 1);
  endfunction

  // Count down one tick; report when the wait has run out
  function automatic logic wait_elapsed();
    if (lk_wait > 16'd1) begin
      lk_wait = lk_wait - 16'd1;
      return 1'b0;
    end
    lk_wait = '0;
    return 1'b1;
  endfunction

  function automatic logic code_accepted();
    for (int i = 0; i < CODE_LENGTH_DEF; i++) begin
      if (lk_digits[i] != cfg_code[4 * (CODE_LENGTH_DEF - 1 - i) +: 4]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void reset_lock_model();
    lk_phase   = PH_IDLE;
    lk_wait    = '0;
    lk_key     = '0;
    lk_count   = '0;
    lk_verdict = VERDICT_NONE;
    lk_motor   = BRIDGE_OFF;
    cfg_code   = SECRET_CODE_RST;
    cfg_ticks  = DEBOUNCE_TICKS_RST;
    for (int i = 0; i < CODE_LENGTH_DEF; i++) lk_digits[i] = '0;
  endfunction

  // Advance the lock model by one tick and return the status it shows afterwards
  function automatic lock_status_t next_lock_status(logic [9:0] keys, logic start,
                                                    logic motor);
    lock_status_t st;
    logic         echo;
    echo = 1'b0;
    st   = '0;
    case (lk_phase)
      PH_IDLE: begin
        if (start) begin
          lk_phase = PH_COLLECT;
          lk_count = '0;
        end
      end
      PH_COLLECT: begin
        if (keys != '0) begin
          // lowest set bit wins when several keys are down
          for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (keys[k]) lk_key = KEY_IDX_W'(k);
          end
          lk_wait  = cfg_ticks;
          lk_phase = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (wait_elapsed()) lk_phase = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (!keys[lk_key]) begin
          if (lk_count < CODE_LENGTH_DEF) begin
            lk_digits[lk_count[1:0]] = face_digit(lk_key);
            lk_count = lk_count + 3'd1;
          end
          echo     = 1'b1;
          lk_wait  = cfg_ticks;
          lk_phase = PH_HOLDOFF;
        end
      end
      PH_HOLDOFF: begin
        if (wait_elapsed()) begin
          if (lk_count >= CODE_LENGTH_DEF) begin
            if (code_accepted()) begin
              lk_verdict = VERDICT_GRANTED;
              lk_motor   = motor ? BRIDGE_OFF : BRIDGE_REVERSE;
            end else begin
              lk_verdict = VERDICT_DENIED;
              lk_motor   = BRIDGE_OFF;
            end
            lk_phase = PH_DONE;
          end else begin
            lk_phase = PH_COLLECT;
          end
        end
      end
      default: begin
        lk_phase = PH_DONE;
      end
    endcase
    st.session_active = (lk_phase >= PH_COLLECT) && (lk_phase <= PH_HOLDOFF);
    st.digits_entered = lk_count;
    st.echo_star      = echo;
    st.verdict        = lk_verdict;
    st.bridge_a       = lk_motor[0];
    st.bridge_b       = lk_motor[1];
    return st;
  endfunction

  // Offer one tick item, idling first at random; predict once it is taken
  task automatic send_tick(logic [9:0] keys, logic start, logic motor);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, motor, start, keys};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_status.push_back(next_lock_status(keys, start, motor));
  endtask

  task automatic send_noise();
    send_tick(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Keep feeding noise while the lock model stays in one phase
  task automatic ride_phase(phase_t ph);
    while (lk_phase == ph) send_noise();
  endtask

  // Drop valid and hold until every predicted item has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_CODE) cfg_code = value;
    else cfg_ticks = value;
    @(posedge clk);
  endtask

  task automatic apb_read_check(logic [APB_ADDR_W-1:0] addr, logic [15:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, want}) report_mismatch("register readback", prdata, 32'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_and_verify(logic [APB_ADDR_W-1:0] addr, logic [15:0] value);
    apb_write(addr, value);
    apb_read_check(addr, value);
  endtask

  function automatic logic [9:0] random_press();
    if ($urandom_range(0, 1) == 1) return 10'b1 << $urandom_range(0, 9);
    return 10'($urandom_range(1, 1023));
  endfunction

  // Enter one digit from the collect phase: gap, press, debounce, hold, release
  task automatic press_digit(logic [9:0] press_map, int gap, int hold);
    logic [9:0] noise;
    logic [9:0] held_bit;
    repeat (gap) send_tick('0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_tick(press_map, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    ride_phase(PH_DEBOUNCE);
    held_bit = 10'b1 << lk_key;
    while (lk_phase == PH_RELEASE) begin
      noise = 10'($urandom_range(0, 1023));
      if (hold > 0) begin
        send_tick(noise | held_bit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        hold--;
      end else begin
        send_tick(noise & ~held_bit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_register_defaults();
    apb_read_check(ADDR_CODE, SECRET_CODE_RST);
    apb_read_check(ADDR_TICKS, DEBOUNCE_TICKS_RST);
  endtask

  // Extreme and non-BCD codes, extreme tick counts; leaves a zero debounce behind
  task automatic test_register_extremes();
    write_and_verify(ADDR_CODE, 16'h0000);
    write_and_verify(ADDR_CODE, 16'h9999);
    write_and_verify(ADDR_CODE, 16'hFFFF);
    write_and_verify(ADDR_CODE, 16'h12A4);
    write_and_verify(ADDR_TICKS, 16'd1);
    write_and_verify(ADDR_TICKS, 16'hFFFF);
    write_and_verify(ADDR_TICKS, 16'd0);
  endtask

  // Keys while idle must be ignored: all keys, each key alone, motor both ways
  task automatic test_idle_keys();
    send_tick(10'h000, 1'b0, 1'b0);
    send_tick(10'h3FF, 1'b0, 1'b1);
    for (int k = 0; k < KEY_COUNT; k++) send_tick(10'b1 << k, 1'b0, 1'(k));
  endtask

  task automatic test_idle_noise();
    repeat (150) send_tick(10'($urandom_range(0, 1023)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Open a session, repeat start inside it, enter a multi-key press with zero debounce
  task automatic test_session_open();
    send_tick(10'h3FF, 1'b1, 1'b0);
    send_tick(10'h000, 1'b1, 1'b1);
    send_tick(10'h000, 1'b1, 1'b0);
    press_digit(10'h3F8, 0, 2);
    ride_phase(PH_HOLDOFF);
  endtask

  // Remaining digits with fresh settings between them and each idling pattern
  task automatic test_digit_entry();
    settle();
    apb_write(ADDR_TICKS, 16'd1);
    apb_write(ADDR_CODE, 16'h9999);
    press_digit(random_press(), $urandom_range(0, 8), $urandom_range(0, 40));
    ride_phase(PH_HOLDOFF);

    settle();
    tx_idle_pct = 87;
    rx_idle_pct = 6;
    apb_write(ADDR_TICKS, 16'($urandom_range(280, 420)));
    apb_write(ADDR_CODE, 16'h0000);
    press_digit(random_press(), $urandom_range(0, 8), $urandom_range(0, 40));
    ride_phase(PH_HOLDOFF);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(ADDR_TICKS, 16'($urandom_range(280, 420)));
    press_digit(random_press(), $urandom_range(0, 8), $urandom_range(0, 40));
  endtask

  // Pause in the last holdoff, set a matching or wrong code, then run to the verdict
  task automatic test_verdict();
    logic [15:0] entered;
    logic [15:0] code;
    settle();
    entered = {lk_digits[0], lk_digits[1], lk_digits[2], lk_digits[3]};
    case ($urandom_range(0, 3))
      0, 1:    code = entered;
      2:       code = entered ^ (16'h0001 << (4 * $urandom_range(0, 3)));
      default: code = 16'($urandom_range(0, 65535));
    endcase
    apb_write(ADDR_CODE, code);
    ride_phase(PH_HOLDOFF);
  endtask

  // Once halted nothing moves: keys and start are ignored
  task automatic test_halted();
    repeat (60) send_noise();
  endtask

  // Check each returned status item against the oldest prediction
  always @(posedge clk) begin : status_check
    lock_status_t got;
    lock_status_t want;
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status item with none expected", 32'(m_tdata), '0);
      end else begin
        want = pending_status.pop_front();
        got  = m_tdata;
        if (got.session_active !== want.session_active)
          report_mismatch("session_active", 32'(got.session_active),
                          32'(want.session_active));
        if (got.digits_entered !== want.digits_entered)
          report_mismatch("digits_entered", 32'(got.digits_entered),
                          32'(want.digits_entered));
        if (got.echo_star !== want.echo_star)
          report_mismatch("echo_star", 32'(got.echo_star), 32'(want.echo_star));
        if (got.verdict !== want.verdict)
          report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
        if (got.bridge_a !== want.bridge_a)
          report_mismatch("bridge_a", 32'(got.bridge_a), 32'(want.bridge_a));
        if (got.bridge_b !== want.bridge_b)
          report_mismatch("bridge_b", 32'(got.bridge_b), 32'(want.bridge_b));
        if (got.pad !== want.pad)
          report_mismatch("tdata padding", 32'(got.pad), 32'(want.pad));
      end
    end
  end

  initial begin
    reset_lock_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_register_extremes();
    test_idle_keys();
    test_idle_noise();
    test_session_open();
    test_digit_entry();
    test_verdict();
    test_halted();
    settle();
    // allow for the queue and output register in case anything stray follows
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
